FILE: design/rtss_pkg.sv
// shared types and codes for the resistive touch scan sequencer
`default_nettype none

package rtss_pkg;

    // scan phase
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_Y_SETTLE = 3'd1,
        PH_Y_CONV   = 3'd2,
        PH_X_SETTLE = 3'd3,
        PH_X_CONV   = 3'd4,
        PH_RECHECK  = 3'd5,
        PH_PAUSE    = 3'd6
    } t_phase;

    typedef logic [1:0] t_drive_mode;
    localparam t_drive_mode DRIVE_DETECT  = 2'd0;
    localparam t_drive_mode DRIVE_Y       = 2'd1;
    localparam t_drive_mode DRIVE_X       = 2'd2;
    localparam t_drive_mode DRIVE_RECHECK = 2'd3;

    typedef logic [2:0] t_adc_chan;
    localparam t_adc_chan ADC_CHAN_Y = 3'd4;
    localparam t_adc_chan ADC_CHAN_X = 3'd5;

    typedef logic [1:0] t_touch_event;
    localparam t_touch_event EVT_NONE    = 2'd0;
    localparam t_touch_event EVT_PRESS   = 2'd1;
    localparam t_touch_event EVT_RELEASE = 2'd2;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_SETTLE   = 2'd0;
    localparam t_cfg_index CFG_RECHECK  = 2'd1;
    localparam t_cfg_index CFG_INTERVAL = 2'd2;

    localparam int CFG_BITS = 16;

    localparam logic [CFG_BITS-1:0] SETTLE_RESET   = 16'd100;
    localparam logic [CFG_BITS-1:0] RECHECK_RESET  = 16'd200;
    localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 16'd1000;

    // sample filter fill level
    typedef logic [1:0] t_sample_cnt;
    localparam t_sample_cnt SMP_NONE    = 2'd0;
    localparam t_sample_cnt SMP_DROPPED = 2'd1;
    localparam t_sample_cnt SMP_HELD    = 2'd2;
    localparam t_sample_cnt SMP_REPORT  = 2'd3;

endpackage

`default_nettype wire

FILE: design/resistive_touch_scan_sequencer.sv
// top level of the four-wire resistive touch scan sequencer
//
// one input transaction per timer tick carries the pen-detect level and any
// finished converter result; every input transaction yields exactly one
// output transaction with the plate drive mode, the converter start pulse and
// channel, an optional coordinate report and a press/release event
// the result of an accepted tick is registered into the output register, or
// into the skid entry while a result waits there; throughput is one tick per
// cycle while o_stall is low, set by the single pass of the phase machine and
// wait counter between the input handshake and the output register
// the output register is backed by a one-entry skid buffer, so a tick is
// still taken while a result waits; o_stall rises only when the skid entry
// is occupied and clears once the receiver takes the waiting result
// configuration (settle, recheck, interval tick counts) is written through
// i_cfg_we / i_cfg_index / i_cfg_data, by the user only while no tick is in
// flight, not enforced by the block; synchronous active-low reset returns to
// idle detect, clears the sample filter, loads default waits (100, 200, 1000)
`default_nettype none

module resistive_touch_scan_sequencer #(
    parameter int COORD_BITS      = 10,
    parameter int TICK_COUNT_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write port
    input  wire                              i_cfg_we,
    input  wire rtss_pkg::t_cfg_index        i_cfg_index,
    input  wire [rtss_pkg::CFG_BITS-1:0]     i_cfg_data,
    // tick input channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_pen_detect,
    input  wire                              i_adc_done,
    input  wire [COORD_BITS-1:0]             i_adc_value,
    // result output channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output rtss_pkg::t_drive_mode            o_drive_mode,
    output logic                             o_adc_start,
    output rtss_pkg::t_adc_chan              o_adc_channel,
    output logic                             o_report_valid,
    output logic [COORD_BITS-1:0]            o_report_x,
    output logic [COORD_BITS-1:0]            o_report_y,
    output rtss_pkg::t_touch_event           o_touch_event,
    output logic                             o_touch_active
);
    import rtss_pkg::*;

    // compare width covers both the config registers and the counter
    localparam int LW = (TICK_COUNT_BITS > CFG_BITS) ? TICK_COUNT_BITS : CFG_BITS;
    localparam logic [LW-1:0] TICK_MAX = LW'((64'd1 << TICK_COUNT_BITS) - 64'd1);

    typedef struct packed {
        t_drive_mode           drive_mode;
        logic                  adc_start;
        t_adc_chan             adc_channel;
        logic                  report_valid;
        logic [COORD_BITS-1:0] report_x;
        logic [COORD_BITS-1:0] report_y;
        t_touch_event          touch_event;
        logic                  touch_active;
    } t_result;

    // configuration registers
    logic [CFG_BITS-1:0] r_settle_ticks;
    logic [CFG_BITS-1:0] r_recheck_ticks;
    logic [CFG_BITS-1:0] r_interval_ticks;

    // scan state
    t_phase                      r_phase, n_phase;
    logic [TICK_COUNT_BITS-1:0]  r_tick, n_tick;
    t_sample_cnt                 r_sample, n_sample;
    logic [COORD_BITS-1:0]       r_held_x, n_held_x;
    logic [COORD_BITS-1:0]       r_held_y, n_held_y;
    logic [COORD_BITS-1:0]       r_meas_x, n_meas_x;
    logic [COORD_BITS-1:0]       r_meas_y, n_meas_y;
    logic                        r_touch, n_touch;

    // output register and skid entry
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    t_result result;

    // per-tick scratch
    logic                       in_accept;
    logic                       out_take;
    logic [TICK_COUNT_BITS-1:0] tick_inc;
    logic [CFG_BITS-1:0]        lim_sel;
    logic [LW-1:0]              lim_sat;
    logic                       wait_done;
    logic                       start;
    logic                       rvalid;
    logic [COORD_BITS-1:0]      rx, ry;
    t_touch_event               evt;
    logic                       leave;

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_stall;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks   <= SETTLE_RESET;
            r_recheck_ticks  <= RECHECK_RESET;
            r_interval_ticks <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SETTLE:   r_settle_ticks   <= i_cfg_data;
                CFG_RECHECK:  r_recheck_ticks  <= i_cfg_data;
                CFG_INTERVAL: r_interval_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // wait counter: saturating increment, zero limit acts as one,
    // limit clipped to the counter maximum
    // ---------------------------------------------------------------
    always_comb begin
        tick_inc = (r_tick == {TICK_COUNT_BITS{1'b1}}) ? r_tick : r_tick + 1'b1;
        case (r_phase)
            PH_RECHECK: lim_sel = r_recheck_ticks;
            PH_PAUSE:   lim_sel = r_interval_ticks;
            default:    lim_sel = r_settle_ticks;
        endcase
        lim_sat = (lim_sel == '0) ? LW'(1) : LW'(lim_sel);
        if (lim_sat > TICK_MAX) begin
            lim_sat = TICK_MAX;
        end
        wait_done = LW'(tick_inc) >= lim_sat;
    end

    // ---------------------------------------------------------------
    // next state for one tick
    // ---------------------------------------------------------------
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_sample = r_sample;
        n_held_x = r_held_x;
        n_held_y = r_held_y;
        n_meas_x = r_meas_x;
        n_meas_y = r_meas_y;
        n_touch  = r_touch;
        start    = 1'b0;
        rvalid   = 1'b0;
        rx       = '0;
        ry       = '0;
        evt      = EVT_NONE;
        leave    = 1'b0;

        unique case (r_phase)
            PH_Y_SETTLE, PH_X_SETTLE: begin
                n_tick = tick_inc;
                if (wait_done) begin
                    start   = 1'b1;
                    n_phase = (r_phase == PH_Y_SETTLE) ? PH_Y_CONV : PH_X_CONV;
                end
            end
            PH_Y_CONV: begin
                if (i_adc_done) begin
                    n_meas_y = i_adc_value;
                    n_phase  = PH_X_SETTLE;
                    n_tick   = '0;
                end
            end
            PH_X_CONV: begin
                if (i_adc_done) begin
                    n_meas_x = i_adc_value;
                    n_phase  = PH_RECHECK;
                    n_tick   = '0;
                end
            end
            PH_RECHECK: begin
                n_tick = tick_inc;
                if (wait_done) begin
                    if (!i_pen_detect) begin
                        leave = 1'b1;
                    end else begin
                        case (r_sample)
                            SMP_NONE:    n_sample = SMP_DROPPED;
                            SMP_DROPPED: n_sample = SMP_HELD;
                            default: begin
                                // filter full: report the held pair
                                if (r_sample == SMP_HELD) begin
                                    evt      = EVT_PRESS;
                                    n_touch  = 1'b1;
                                    n_sample = SMP_REPORT;
                                end
                                rvalid = 1'b1;
                                rx     = r_held_x;
                                ry     = r_held_y;
                            end
                        endcase
                        if (n_sample == SMP_HELD || n_sample == SMP_REPORT) begin
                            n_held_x = r_meas_x;
                            n_held_y = r_meas_y;
                        end
                        n_phase = PH_PAUSE;
                        n_tick  = '0;
                    end
                end
            end
            PH_PAUSE: begin
                n_tick = tick_inc;
                if (wait_done) begin
                    if (!i_pen_detect) begin
                        leave = 1'b1;
                    end else begin
                        n_phase = PH_Y_SETTLE;
                        n_tick  = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_pen_detect) begin
                    n_sample = SMP_NONE;
                    n_phase  = PH_Y_SETTLE;
                    n_tick   = '0;
                end
            end
        endcase

        // pen lifted at recheck or end of pause
        if (leave) begin
            if (r_sample != SMP_NONE) begin
                evt     = EVT_RELEASE;
                n_touch = 1'b0;
            end
            n_phase = PH_IDLE;
            n_tick  = '0;
        end
    end

    // ---------------------------------------------------------------
    // result fields, drive mode follows the phase being entered
    // ---------------------------------------------------------------
    always_comb begin
        result = '0;
        result.adc_start    = start;
        result.report_valid = rvalid;
        result.report_x     = rx;
        result.report_y     = ry;
        result.touch_event  = evt;
        result.touch_active = n_touch;
        result.adc_channel  = ADC_CHAN_Y;
        unique case (n_phase)
            PH_Y_SETTLE, PH_Y_CONV: result.drive_mode = DRIVE_Y;
            PH_X_SETTLE, PH_X_CONV: begin
                result.drive_mode  = DRIVE_X;
                result.adc_channel = ADC_CHAN_X;
            end
            PH_RECHECK, PH_PAUSE:   result.drive_mode = DRIVE_RECHECK;
            default:                result.drive_mode = DRIVE_DETECT;
        endcase
    end

    // ---------------------------------------------------------------
    // state registers, advanced once per accepted tick
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_sample <= SMP_NONE;
            r_held_x <= '0;
            r_held_y <= '0;
            r_meas_x <= '0;
            r_meas_y <= '0;
            r_touch  <= 1'b0;
        end else if (in_accept) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_sample <= n_sample;
            r_held_x <= n_held_x;
            r_held_y <= n_held_y;
            r_meas_x <= n_meas_x;
            r_meas_y <= n_meas_y;
            r_touch  <= n_touch;
        end
    end

    // ---------------------------------------------------------------
    // output register with skid entry
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_take) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_drive_mode   = r_out.drive_mode;
    assign o_adc_start    = r_out.adc_start;
    assign o_adc_channel  = r_out.adc_channel;
    assign o_report_valid = r_out.report_valid;
    assign o_report_x     = r_out.report_x;
    assign o_report_y     = r_out.report_y;
    assign o_touch_event  = r_out.touch_event;
    assign o_touch_active = r_out.touch_active;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // reports only come out of the recheck step, which enters the pause
    a_report_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.report_valid) |-> (r_out.drive_mode == DRIVE_RECHECK))
        else $error("coordinate report outside recheck drive mode");

    // press event always rides on a report and sets the touch state
    a_press_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.touch_event == EVT_PRESS)
            |-> (r_out.report_valid && r_out.touch_active))
        else $error("press event without report");

    // a conversion is started only with the plates driven for it
    a_start_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.adc_start)
            |-> (r_out.drive_mode == DRIVE_Y || r_out.drive_mode == DRIVE_X))
        else $error("conversion started outside a measure drive mode");

    // the sample count never changes without an accepted tick
    a_sample_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sample != $past(r_sample)) |-> $past(in_accept))
        else $error("sample count changed without a tick");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench for the resistive touch scan sequencer, directed and random tick streams
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtss_pkg::*;

    localparam int COORD_W        = 10;
    localparam int TICK_W         = 16;
    localparam int RANDOM_TICKS   = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTED   = 10;
    localparam logic [TICK_W-1:0]   TICK_MAX = '1;

    // what one tick should produce on the result channel
    typedef struct packed {
        t_drive_mode        mode;
        logic               adc_start;
        t_adc_chan          chan;
        logic               report_valid;
        logic [COORD_W-1:0] report_x;
        logic [COORD_W-1:0] report_y;
        t_touch_event       evt;
        logic               active;
    } t_tick_outcome;

    // ------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    t_cfg_index           i_cfg_index  = CFG_SETTLE;
    logic [CFG_BITS-1:0]  i_cfg_data   = '0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic                 i_pen_detect = 1'b0;
    logic                 i_adc_done   = 1'b0;
    logic [COORD_W-1:0]   i_adc_value  = '0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    t_drive_mode          o_drive_mode;
    logic                 o_adc_start;
    t_adc_chan            o_adc_channel;
    logic                 o_report_valid;
    logic [COORD_W-1:0]   o_report_x;
    logic [COORD_W-1:0]   o_report_y;
    t_touch_event         o_touch_event;
    logic                 o_touch_active;

    resistive_touch_scan_sequencer #(
        .COORD_BITS      (COORD_W),
        .TICK_COUNT_BITS (TICK_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pen_detect   (i_pen_detect),
        .i_adc_done     (i_adc_done),
        .i_adc_value    (i_adc_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive_mode   (o_drive_mode),
        .o_adc_start    (o_adc_start),
        .o_adc_channel  (o_adc_channel),
        .o_report_valid (o_report_valid),
        .o_report_x     (o_report_x),
        .o_report_y     (o_report_y),
        .o_touch_event  (o_touch_event),
        .o_touch_active (o_touch_active)
    );

    // ------------------------------------------------------------------
    // scan sequencer shadow state, stepped once per accepted tick
    // ------------------------------------------------------------------
    t_phase              scan_phase;
    logic [TICK_W-1:0]   wait_cnt;
    t_sample_cnt         sample_lvl;
    logic [COORD_W-1:0]  held_x, held_y, meas_x, meas_y;
    logic                touch_flag;
    logic [CFG_BITS-1:0] settle_cfg, recheck_cfg, interval_cfg;

    t_tick_outcome pending_tick_outcomes[$];

    // run bookkeeping
    bit steady_flow  = 1'b0;   // both sides run without gaps while set
    int ticks_sent   = 0;
    int cfg_writes   = 0;
    int mismatches   = 0;
    int outcomes_checked = 0;
    int reports_seen = 0;
    int presses_seen = 0;
    int releases_seen = 0;
    int idle_cycles  = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit take_break();
        return !steady_flow && ($urandom_range(0, 99) < 20);
    endfunction

    // mostly uniform coordinates, with the two ends of the range showing up often
    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic clear_scan_state();
        settle_cfg   = SETTLE_RESET;
        recheck_cfg  = RECHECK_RESET;
        interval_cfg = INTERVAL_RESET;
        scan_phase   = PH_IDLE;
        wait_cnt     = '0;
        sample_lvl   = SMP_NONE;
        held_x       = '0;
        held_y       = '0;
        meas_x       = '0;
        meas_y       = '0;
        touch_flag   = 1'b0;
    endtask

    // wait counter: a zero count acts as one, the counter stops at its top value
    function automatic logic wait_over(input logic [CFG_BITS-1:0] limit);
        logic [TICK_W-1:0] lim;
        lim = (limit == '0) ? TICK_W'(1) : TICK_W'(limit);
        if (wait_cnt != TICK_MAX)
            wait_cnt++;
        return wait_cnt >= lim;
    endfunction

    // one tick of the scan: phase machine, sample filter and output mapping
    task automatic sequence_tick(input logic pen, input logic done,
                                 input logic [COORD_W-1:0] value);
        t_tick_outcome r;
        logic          leave;
        r     = '0;
        leave = 1'b0;
        case (scan_phase)
            PH_Y_SETTLE: begin
                if (wait_over(settle_cfg)) begin
                    r.adc_start = 1'b1;
                    scan_phase  = PH_Y_CONV;
                end
            end
            PH_Y_CONV: begin
                if (done) begin
                    meas_y     = value;
                    scan_phase = PH_X_SETTLE;
                    wait_cnt   = '0;
                end
            end
            PH_X_SETTLE: begin
                if (wait_over(settle_cfg)) begin
                    r.adc_start = 1'b1;
                    scan_phase  = PH_X_CONV;
                end
            end
            PH_X_CONV: begin
                if (done) begin
                    meas_x     = value;
                    scan_phase = PH_RECHECK;
                    wait_cnt   = '0;
                end
            end
            PH_RECHECK: begin
                if (wait_over(recheck_cfg)) begin
                    if (!pen) begin
                        leave = 1'b1;
                    end else begin
                        // first sample dropped, second held, later ones push the held pair out
                        case (sample_lvl)
                            SMP_NONE:    sample_lvl = SMP_DROPPED;
                            SMP_DROPPED: sample_lvl = SMP_HELD;
                            default: begin
                                if (sample_lvl == SMP_HELD) begin
                                    r.evt      = EVT_PRESS;
                                    touch_flag = 1'b1;
                                    sample_lvl = SMP_REPORT;
                                end
                                r.report_valid = 1'b1;
                                r.report_x     = held_x;
                                r.report_y     = held_y;
                            end
                        endcase
                        if (sample_lvl >= SMP_HELD) begin
                            held_x = meas_x;
                            held_y = meas_y;
                        end
                        scan_phase = PH_PAUSE;
                        wait_cnt   = '0;
                    end
                end
            end
            PH_PAUSE: begin
                if (wait_over(interval_cfg)) begin
                    if (!pen) begin
                        leave = 1'b1;
                    end else begin
                        scan_phase = PH_Y_SETTLE;
                        wait_cnt   = '0;
                    end
                end
            end
            default: begin
                scan_phase = PH_IDLE;
                if (pen) begin
                    sample_lvl = SMP_NONE;
                    scan_phase = PH_Y_SETTLE;
                    wait_cnt   = '0;
                end
            end
        endcase

        // pen gone: a release goes out whenever any sample was taken, even a dropped one
        if (leave) begin
            if (sample_lvl != SMP_NONE) begin
                r.evt      = EVT_RELEASE;
                touch_flag = 1'b0;
            end
            scan_phase = PH_IDLE;
            wait_cnt   = '0;
        end

        r.chan = ADC_CHAN_Y;
        case (scan_phase)
            PH_Y_SETTLE, PH_Y_CONV: r.mode = DRIVE_Y;
            PH_X_SETTLE, PH_X_CONV: begin
                r.mode = DRIVE_X;
                r.chan = ADC_CHAN_X;
            end
            PH_RECHECK, PH_PAUSE: r.mode = DRIVE_RECHECK;
            default: r.mode = DRIVE_DETECT;
        endcase
        r.active = touch_flag;
        pending_tick_outcomes.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // tick channel driver: payload set at the falling edge, held until taken
    // ------------------------------------------------------------------
    task automatic send_tick(input logic pen, input logic done,
                             input logic [COORD_W-1:0] value);
        while (take_break()) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_pen_detect <= pen;
        i_adc_done   <= done;
        i_adc_value  <= value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sequence_tick(pen, done, value);
        ticks_sent++;
    endtask

    // random tick: conversions finish at done_pct while one is pending, stray
    // done flags show up at stray_pct elsewhere
    task automatic scan_tick(input logic pen, input int done_pct, input int stray_pct);
        logic converting;
        logic done;
        converting = (scan_phase == PH_Y_CONV) || (scan_phase == PH_X_CONV);
        done = converting ? ($urandom_range(0, 99) < done_pct)
                          : ($urandom_range(0, 99) < stray_pct);
        send_tick(pen, done, random_coord());
    endtask

    // step at least once, then until the scan sits in the target phase;
    // conversions finish at once, Y gets value and X its complement
    task automatic advance_to(input t_phase target, input logic pen,
                              input logic [COORD_W-1:0] value, input logic stray);
        logic converting;
        do begin
            converting = (scan_phase == PH_Y_CONV) || (scan_phase == PH_X_CONV);
            send_tick(pen, converting ? 1'b1 : stray,
                      (scan_phase == PH_X_CONV) ? ~value : value);
        end while (scan_phase != target);
    endtask

    // sender holds off until every tick in flight has its result back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_tick_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SETTLE:   settle_cfg   = value;
            CFG_RECHECK:  recheck_cfg  = value;
            CFG_INTERVAL: interval_cfg = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_waits(input logic [CFG_BITS-1:0] settle,
                             input logic [CFG_BITS-1:0] recheck,
                             input logic [CFG_BITS-1:0] interval);
        wait_drained();
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_RECHECK, recheck);
        write_reg(CFG_INTERVAL, interval);
    endtask

    // ------------------------------------------------------------------
    // result channel: receiver stalls at random, every transaction checked
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            i_stall <= take_break();
        end
    end

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatches < MAX_REPORTED)
            $display("mismatch on result %0d: %s expected %0d got %0d",
                     outcomes_checked, field, want, got);
        mismatches++;
    endtask

    task automatic check_tick_outcome();
        t_tick_outcome want;
        if (pending_tick_outcomes.size() == 0) begin
            if (mismatches < MAX_REPORTED)
                $display("result transaction with no tick waiting for it");
            mismatches++;
            return;
        end
        want = pending_tick_outcomes.pop_front();
        if (o_drive_mode !== want.mode)
            note_mismatch("drive_mode", 32'(want.mode), 32'(o_drive_mode));
        if (o_adc_start !== want.adc_start)
            note_mismatch("adc_start", 32'(want.adc_start), 32'(o_adc_start));
        if (o_adc_channel !== want.chan)
            note_mismatch("adc_channel", 32'(want.chan), 32'(o_adc_channel));
        if (o_report_valid !== want.report_valid)
            note_mismatch("report_valid", 32'(want.report_valid), 32'(o_report_valid));
        if (o_report_x !== want.report_x)
            note_mismatch("report_x", 32'(want.report_x), 32'(o_report_x));
        if (o_report_y !== want.report_y)
            note_mismatch("report_y", 32'(want.report_y), 32'(o_report_y));
        if (o_touch_event !== want.evt)
            note_mismatch("touch_event", 32'(want.evt), 32'(o_touch_event));
        if (o_touch_active !== want.active)
            note_mismatch("touch_active", 32'(want.active), 32'(o_touch_active));
        if (want.report_valid)        reports_seen++;
        if (want.evt == EVT_PRESS)    presses_seen++;
        if (want.evt == EVT_RELEASE)  releases_seen++;
        outcomes_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            check_tick_outcome();
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_tick_outcomes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // settle count straight out of reset, stray conversion flags while idle
    task automatic test_reset_defaults();
        send_tick(1'b0, 1'b1, '1);
        send_tick(1'b0, 1'b1, '0);
        advance_to(PH_Y_CONV, 1'b1, 10'h200, 1'b0);
    endtask

    // zero counts act as one; five samples walk the filter through drop, hold,
    // press and saturation, then lifting the pen in the pause releases
    task automatic test_zero_waits();
        logic [COORD_W-1:0] coords [5];
        coords = '{10'h000, 10'h3FF, 10'h2AA, 10'h155, 10'h001};
        set_waits('0, '0, '0);
        foreach (coords[k])
            advance_to(PH_PAUSE, 1'b1, coords[k], (k % 2) == 1);
        advance_to(PH_IDLE, 1'b0, '0, 1'b0);
    endtask

    // release after only the dropped sample; lift during settle and conversion
    // is ignored until the recheck, which then drops the sample silently
    task automatic test_release_rules();
        set_waits(CFG_BITS'(1), CFG_BITS'(1), CFG_BITS'(1));
        advance_to(PH_PAUSE, 1'b1, 10'h0F0, 1'b0);
        advance_to(PH_IDLE, 1'b0, 10'h30F, 1'b0);
        send_tick(1'b1, 1'b0, random_coord());
        advance_to(PH_RECHECK, 1'b0, 10'h155, 1'b1);
        advance_to(PH_IDLE, 1'b0, 10'h2AA, 1'b1);
    endtask

    // conversions that do not finish keep the scan parked, pen level ignored
    task automatic test_stuck_conversion();
        set_waits(CFG_BITS'(2), CFG_BITS'(3), CFG_BITS'(2));
        advance_to(PH_Y_CONV, 1'b1, '0, 1'b0);
        repeat (12) send_tick(1'($urandom_range(0, 1)), 1'b0, random_coord());
        advance_to(PH_X_CONV, 1'b1, 10'h3C3, 1'b0);
        repeat (12) send_tick(1'($urandom_range(0, 1)), 1'b0, random_coord());
        advance_to(PH_IDLE, 1'b0, '0, 1'b1);
    endtask

    // longer counts on every wait, run as one gap-free stretch
    task automatic test_long_waits();
        set_waits(CFG_BITS'(20), CFG_BITS'(33), CFG_BITS'(40));
        steady_flow = 1'b1;
        advance_to(PH_PAUSE, 1'b1, 10'h2C5, 1'b0);
        advance_to(PH_IDLE, 1'b0, '0, 1'b0);
        steady_flow = 1'b0;
    endtask

    function automatic logic [CFG_BITS-1:0] pick_wait();
        if ($urandom_range(0, 7) == 0)
            return CFG_BITS'($urandom_range(5, 12));
        return CFG_BITS'($urandom_range(0, 4));
    endfunction

    // touch sessions with short random counts: mostly a held pen with rare
    // flicker, some pure noise, each session run out until the scan is idle
    task automatic test_random_sessions();
        int first_tick;
        int hold;
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < RANDOM_TICKS) begin
            set_waits(pick_wait(), pick_wait(), pick_wait());
            steady_flow = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8) begin
                hold = $urandom_range(10, 90);
                repeat (hold) scan_tick($urandom_range(0, 99) >= 3, 40, 5);
            end else begin
                hold = $urandom_range(5, 30);
                repeat (hold)
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              random_coord());
            end
            while (scan_phase != PH_IDLE)
                scan_tick(1'b0, 50, 5);
            steady_flow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_scan_state();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_waits();
        test_release_rules();
        test_stuck_conversion();
        test_long_waits();
        test_random_sessions();

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("sent %0d ticks through directed and random touch sessions, %0d reg writes",
                 ticks_sent, cfg_writes);
        $display("checked %0d results: %0d coordinate reports, %0d presses, %0d releases",
                 outcomes_checked, reports_seen, presses_seen, releases_seen);
        if (mismatches == 0 && pending_tick_outcomes.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
